// File: sv/mda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mda_pkg;

  localparam int DefMaxSize = 4;
  localparam int ValW       = 64;
  localparam int ElemW      = 16;
  localparam int CfgW       = 16;

  typedef enum logic [1:0] {
    MODE_DET = 2'd0,
    MODE_COF = 2'd1,
    MODE_ADJ = 2'd2,
    MODE_INV = 2'd3
  } mode_e;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SIZE   = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // Determinant of an empty matrix, 1.0 in Q.8.
  localparam logic signed [ValW-1:0] OneQ8 = 64'sd256;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_START   = 12'b000000000010,
    ST_ENTER   = 12'b000000000100,
    ST_NEXT    = 12'b000000001000,
    ST_RET     = 12'b000000010000,
    ST_RD      = 12'b000000100000,
    ST_MUL     = 12'b000001000000,
    ST_ACC     = 12'b000010000000,
    ST_JOBDONE = 12'b000100000000,
    ST_COF     = 12'b001000000000,
    ST_DIV     = 12'b010000000000,
    ST_DIVFIN  = 12'b100000000000
  } state_e;

  function automatic logic [ValW-1:0] mag64(input logic [ValW-1:0] a);
    return a[ValW-1] ? (~a + 64'd1) : a;
  endfunction

endpackage
`default_nettype wire

// File: sv/matrix_det_adjugate_inverse.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Ports                                   | Transfer
// ----------+-----------+-----------------------------------------+---------------------------
// element   | in        | element_value_i                         | start high, busy low
// result    | out       | value_o row_o col_o is_determinant_o    | result_valid_o, one cycle
//           |           | singular_o last_o                       |
// config    | in        | cfg_we_i cfg_index_i cfg_data_i         | cfg_we_i high
//
// Elements load one per cycle while start is high and busy is low; busy rises after the last element of a matrix.
// A stack-based sequencer around one shared multiply-accumulate unit expands a k-by-k
// matrix recursively into its minors; each output entry repeats this for its minor,
// and each inverse entry adds a restoring divider.
// Results leave one per strobe; the receiver cannot stall.
// Reset is asynchronous and active low; the matrix store is not cleared.
module matrix_det_adjugate_inverse #(
  parameter int MAX_SIZE = mda_pkg::DefMaxSize
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire signed [mda_pkg::ElemW-1:0] element_value_i,
  input  wire                            cfg_we_i,
  input  wire [1:0]                      cfg_index_i,
  input  wire [mda_pkg::CfgW-1:0]        cfg_data_i,
  output logic                           result_valid_o,
  output logic signed [mda_pkg::ValW-1:0] value_o,
  output logic [1:0]                     row_o,
  output logic [1:0]                     col_o,
  output logic                           is_determinant_o,
  output logic                           singular_o,
  output logic                           last_o
);
  import mda_pkg::*;

  localparam int Cells = MAX_SIZE * MAX_SIZE;
  localparam int AddrW = $clog2(Cells);
  localparam int LcW   = $clog2(Cells + 1);
  localparam int Lvls  = MAX_SIZE + 1;
  localparam int LvlW  = $clog2(Lvls);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int RowW  = (MAX_SIZE > 4) ? 3 : 2;

  state_e state_q, state_d;
  logic [1:0]  mode_q, mode_d;
  logic [2:0]  size_q, size_d;
  logic [15:0] thr_q, thr_d;
  logic [LcW-1:0] load_cnt_q, load_cnt_d;

  logic [LvlW-1:0] d_q, d_d;
  logic [MAX_SIZE-1:0] avail_q [Lvls];
  logic [MAX_SIZE-1:0] avail_d [Lvls];
  logic [MAX_SIZE-1:0] rem_q [Lvls];
  logic [MAX_SIZE-1:0] rem_d [Lvls];
  logic signed [ValW-1:0] acc_q [Lvls];
  logic signed [ValW-1:0] acc_d [Lvls];
  logic par_q [Lvls];
  logic par_d [Lvls];
  logic [RowW-1:0] cur_q [Lvls];
  logic [RowW-1:0] cur_d [Lvls];

  logic signed [ValW-1:0] ret_q, ret_d, det_q, det_d, prod_q, prod_d;
  logic job_det_q, job_det_d, ex_vld_q, ex_vld_d;
  logic [RowW-1:0] ex_row_q, ex_row_d;
  logic [RowW-1:0] i_q, i_d, j_q, j_d;

  logic [ValW-1:0] dv_n_q, dv_n_d, dv_r_q, dv_r_d, dv_den_q, dv_den_d;
  logic dv_neg_q, dv_neg_d;
  logic [6:0] dv_cnt_q, dv_cnt_d;

  logic res_valid_q, res_valid_d;
  logic signed [ValW-1:0] res_val_q, res_val_d;
  logic [1:0] res_row_q, res_row_d, res_col_q, res_col_d;
  logic res_det_q, res_det_d, res_sing_q, res_sing_d, res_last_q, res_last_d;

  logic signed [ElemW-1:0] mem [Cells];
  logic signed [ElemW-1:0] mem_rd_q;
  logic mem_we, mem_re;
  logic [AddrW-1:0] wr_addr, rd_addr;

  logic [NW-1:0] n_eff, n_m1;
  logic [LcW-1:0] total;
  logic [MAX_SIZE-1:0] full_mask, low_bit;
  logic [RowW-1:0] low_c, row_lvl;
  logic [ValW-1:0] rnd_mag;
  logic signed [ValW-1:0] rnd_val, ent_val, num_val, opnd;
  logic signed [ValW+ElemW-1:0] prod_full;
  logic [ValW:0] dv_sh;
  logic ent_last;

  always_comb begin
    if (size_q == 3'd0) begin
      n_eff = NW'(1);
    end else if (int'(size_q) > MAX_SIZE) begin
      n_eff = NW'(MAX_SIZE);
    end else begin
      n_eff = NW'(size_q);
    end
    n_m1  = NW'(n_eff - 1'b1);
    total = LcW'(n_eff) * LcW'(n_eff);
    for (int c = 0; c < MAX_SIZE; c++) begin
      full_mask[c] = (c < int'(n_eff));
    end
  end

  always_comb begin
    low_c = '0;
    for (int c = MAX_SIZE - 1; c >= 0; c--) begin
      if (rem_q[d_q][c]) begin
        low_c = RowW'(c);
      end
    end
    low_bit = {{(MAX_SIZE-1){1'b0}}, 1'b1} << low_c;
    row_lvl = RowW'(d_q);
    if (ex_vld_q && (row_lvl >= ex_row_q)) begin
      row_lvl = RowW'(row_lvl + 1'b1);
    end
    rd_addr = AddrW'(row_lvl) * AddrW'(n_eff) + AddrW'(cur_q[d_q]);
    wr_addr = load_cnt_q[AddrW-1:0];
    // Round Q.16 to Q.8, nearest with ties away from zero.
    rnd_mag = (mag64(acc_q[d_q]) + 64'd128) >> 8;
    rnd_val = acc_q[d_q][ValW-1] ? -$signed(rnd_mag) : $signed(rnd_mag);
    ent_val = (i_q[0] ^ j_q[0]) ? -ret_q : ret_q;
    num_val = ent_val <<< 8;
    opnd = par_q[d_q] ? -ret_q : ret_q;
    prod_full = mem_rd_q * opnd;
    dv_sh = {dv_r_q, dv_n_q[ValW-1]};
    ent_last = (NW'(i_q) == n_m1) && (NW'(j_q) == n_m1);
  end

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    size_d = size_q;
    thr_d = thr_q;
    load_cnt_d = load_cnt_q;
    d_d = d_q;
    avail_d = avail_q;
    rem_d = rem_q;
    acc_d = acc_q;
    par_d = par_q;
    cur_d = cur_q;
    ret_d = ret_q;
    det_d = det_q;
    prod_d = prod_q;
    job_det_d = job_det_q;
    ex_vld_d = ex_vld_q;
    ex_row_d = ex_row_q;
    i_d = i_q;
    j_d = j_q;
    dv_n_d = dv_n_q;
    dv_r_d = dv_r_q;
    dv_den_d = dv_den_q;
    dv_neg_d = dv_neg_q;
    dv_cnt_d = dv_cnt_q;
    res_valid_d = 1'b0;
    res_val_d = res_val_q;
    res_row_d = res_row_q;
    res_col_d = res_col_q;
    res_det_d = res_det_q;
    res_sing_d = res_sing_q;
    res_last_d = res_last_q;
    mem_we = 1'b0;
    mem_re = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          mem_we = 1'b1;
          if (LcW'(load_cnt_q + 1'b1) >= total) begin
            load_cnt_d = '0;
            state_d = ST_START;
          end else begin
            load_cnt_d = LcW'(load_cnt_q + 1'b1);
          end
        end
      end
      ST_START: begin
        ex_vld_d = 1'b0;
        avail_d[0] = full_mask;
        d_d = '0;
        job_det_d = 1'b1;
        state_d = ST_ENTER;
      end
      ST_COF: begin
        ex_vld_d = 1'b1;
        ex_row_d = (mode_q == MODE_COF) ? i_q : j_q;
        avail_d[0] = full_mask &
          ~({{(MAX_SIZE-1){1'b0}}, 1'b1} << ((mode_q == MODE_COF) ? j_q : i_q));
        d_d = '0;
        state_d = ST_ENTER;
      end
      ST_ENTER: begin
        if (avail_q[d_q] == '0) begin
          ret_d = OneQ8;
          state_d = ST_RET;
        end else begin
          acc_d[d_q] = '0;
          par_d[d_q] = 1'b0;
          rem_d[d_q] = avail_q[d_q];
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (rem_q[d_q] == '0) begin
          ret_d = rnd_val;
          state_d = ST_RET;
        end else begin
          cur_d[d_q] = low_c;
          rem_d[d_q] = rem_q[d_q] & ~low_bit;
          avail_d[LvlW'(d_q + 1'b1)] = avail_q[d_q] & ~low_bit;
          d_d = LvlW'(d_q + 1'b1);
          state_d = ST_ENTER;
        end
      end
      ST_RET: begin
        if (d_q == '0) begin
          state_d = ST_JOBDONE;
        end else begin
          d_d = LvlW'(d_q - 1'b1);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        mem_re = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = prod_full[ValW-1:0];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d[d_q] = acc_q[d_q] + prod_q;
        par_d[d_q] = ~par_q[d_q];
        state_d = ST_NEXT;
      end
      ST_JOBDONE: begin
        if (job_det_q) begin
          det_d = ret_q;
          if (mode_q == MODE_DET ||
              (mode_q == MODE_INV &&
               (ret_q == '0 || mag64(ret_q) < {48'd0, thr_q}))) begin
            res_valid_d = 1'b1;
            res_val_d = ret_q;
            res_row_d = 2'd0;
            res_col_d = 2'd0;
            res_det_d = 1'b1;
            res_sing_d = (mode_q == MODE_INV);
            res_last_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            job_det_d = 1'b0;
            i_d = '0;
            j_d = '0;
            state_d = ST_COF;
          end
        end else if (mode_q == MODE_INV) begin
          dv_n_d = mag64(num_val);
          dv_den_d = mag64(det_q);
          dv_r_d = '0;
          dv_neg_d = num_val[ValW-1] ^ det_q[ValW-1];
          dv_cnt_d = '0;
          state_d = ST_DIV;
        end else begin
          res_valid_d = 1'b1;
          res_val_d = ent_val;
          res_row_d = i_q[1:0];
          res_col_d = j_q[1:0];
          res_det_d = 1'b0;
          res_sing_d = 1'b0;
          res_last_d = ent_last;
          if (ent_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_COF;
            if (NW'(j_q) == n_m1) begin
              j_d = '0;
              i_d = RowW'(i_q + 1'b1);
            end else begin
              j_d = RowW'(j_q + 1'b1);
            end
          end
        end
      end
      ST_DIV: begin
        // Restoring division, one quotient bit per cycle shifted into dv_n.
        if (dv_sh >= {1'b0, dv_den_q}) begin
          dv_r_d = ValW'(dv_sh - {1'b0, dv_den_q});
          dv_n_d = {dv_n_q[ValW-2:0], 1'b1};
        end else begin
          dv_r_d = dv_sh[ValW-1:0];
          dv_n_d = {dv_n_q[ValW-2:0], 1'b0};
        end
        dv_cnt_d = 7'(dv_cnt_q + 1'b1);
        if (dv_cnt_q == 7'(ValW - 1)) begin
          state_d = ST_DIVFIN;
        end
      end
      ST_DIVFIN: begin
        res_valid_d = 1'b1;
        res_val_d = dv_neg_q ? -$signed(dv_n_q) : $signed(dv_n_q);
        res_row_d = i_q[1:0];
        res_col_d = j_q[1:0];
        res_det_d = 1'b0;
        res_sing_d = 1'b0;
        res_last_d = ent_last;
        if (ent_last) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_COF;
          if (NW'(j_q) == n_m1) begin
            j_d = '0;
            i_d = RowW'(i_q + 1'b1);
          end else begin
            j_d = RowW'(j_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE: mode_d = cfg_data_i[1:0];
        REG_SIZE: begin
          size_d = cfg_data_i[2:0];
          load_cnt_d = '0;
        end
        REG_THRESH: thr_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= MODE_DET;
      size_q <= 3'd4;
      thr_q <= 16'd1;
      load_cnt_q <= '0;
      d_q <= '0;
      job_det_q <= 1'b0;
      ex_vld_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      dv_cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      size_q <= size_d;
      thr_q <= thr_d;
      load_cnt_q <= load_cnt_d;
      d_q <= d_d;
      job_det_q <= job_det_d;
      ex_vld_q <= ex_vld_d;
      i_q <= i_d;
      j_q <= j_d;
      dv_cnt_q <= dv_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    avail_q <= avail_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    par_q <= par_d;
    cur_q <= cur_d;
    ret_q <= ret_d;
    det_q <= det_d;
    prod_q <= prod_d;
    ex_row_q <= ex_row_d;
    dv_n_q <= dv_n_d;
    dv_r_q <= dv_r_d;
    dv_den_q <= dv_den_d;
    dv_neg_q <= dv_neg_d;
    res_val_q <= res_val_d;
    res_row_q <= res_row_d;
    res_col_q <= res_col_d;
    res_det_q <= res_det_d;
    res_sing_q <= res_sing_d;
    res_last_q <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= element_value_i;
    end
    if (mem_re) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  assign busy = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign value_o = res_val_q;
  assign row_o = res_row_q;
  assign col_o = res_col_q;
  assign is_determinant_o = res_det_q;
  assign singular_o = res_sing_q;
  assign last_o = res_last_q;

endmodule
`default_nettype wire
